@@ rtl/core/cfs_pkg.sv @@
// Shared types and constants for the colon field splitter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package cfs_pkg;

  localparam int FIELD_LIMIT_DEFAULT = 64;

  localparam int BYTE_W       = 8;
  localparam int MAX_FIELDS_W = 7;
  localparam int INDEX_W      = 6;
  localparam int COUNT_W      = 7;

  localparam logic [MAX_FIELDS_W-1:0] MAX_FIELDS_RESET = 7'd64;

  // One result per input byte.
  typedef struct packed {
    logic               field_start;
    logic               field_byte;
    logic [INDEX_W-1:0] field_index;
    logic               line_done;
    logic [COUNT_W-1:0] field_count;
    logic               parse_error;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/cfs_if.sv @@
// Handshake channels of the colon field splitter: input bytes and results.
// Depends on cfs_pkg for the field widths.
`default_nettype none

interface cfs_line_if;
  logic                      valid;
  logic                      ready;
  logic [cfs_pkg::BYTE_W-1:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

interface cfs_result_if;
  logic                        valid;
  logic                        ready;
  logic                        field_start;
  logic                        field_byte;
  logic [cfs_pkg::INDEX_W-1:0] field_index;
  logic                        line_done;
  logic [cfs_pkg::COUNT_W-1:0] field_count;
  logic                        parse_error;

  modport source (output valid, output field_start, output field_byte, output field_index,
                  output line_done, output field_count, output parse_error, input ready);
  modport sink   (input valid, input field_start, input field_byte, input field_index,
                  input line_done, input field_count, input parse_error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cfs_in_stage.sv @@
// Input register of the colon field splitter: holds one accepted byte.
// Depends on cfs_pkg and the cfs_line_if interface.
`default_nettype none

module cfs_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  cfs_line_if.sink                        line,
  input  wire logic                       advance,
  output logic                            held_valid,
  output logic [cfs_pkg::BYTE_W-1:0]      held_byte
);

  // A new request enters when the register is empty or drains this cycle.
  assign line.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (line.ready) begin
      held_valid <= line.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (line.ready && line.valid) begin
      held_byte <= line.byte_value;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cfs_parser.sv @@
// Line parser of the colon field splitter: mode state and per-byte decode.
// Depends on cfs_pkg for the result type and widths.
`default_nettype none

module cfs_parser #(
  parameter int FIELD_LIMIT = cfs_pkg::FIELD_LIMIT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [cfs_pkg::BYTE_W-1:0]       byte_value,
  input  wire logic [cfs_pkg::MAX_FIELDS_W-1:0] max_fields,
  output cfs_pkg::result_t                      result
);

  localparam int CNT_W = $clog2(FIELD_LIMIT + 1);
  localparam int CMP_W = (CNT_W > cfs_pkg::COUNT_W) ? CNT_W : cfs_pkg::COUNT_W;

  localparam logic [cfs_pkg::BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [cfs_pkg::BYTE_W-1:0] CH_STAR  = 8'h2A;

  typedef enum logic [7:0] {
    MODE_START  = 8'b0000_0001,
    MODE_DATA   = 8'b0000_0010,
    MODE_AFTER  = 8'b0000_0100,
    MODE_SLASH  = 8'b0000_1000,
    MODE_REMARK = 8'b0001_0000,
    MODE_RSTAR  = 8'b0010_0000,
    MODE_ERROR  = 8'b0100_0000,
    MODE_IGNORE = 8'b1000_0000
  } mode_t;

  function automatic logic is_data(input logic [cfs_pkg::BYTE_W-1:0] c);
    is_data = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
              (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER;
  endfunction

  mode_t            mode, mode_next;
  logic             resume, resume_next;
  logic [CNT_W-1:0] found, found_next;

  logic [CMP_W-1:0] found_ext, found_plus, found_minus, limit;
  logic             ws, data_c, at_limit;

  always_comb begin
    found_ext   = CMP_W'(found);
    found_plus  = found_ext + CMP_W'(1);
    found_minus = found_ext - CMP_W'(1);
    if (CMP_W'(max_fields) > CMP_W'(FIELD_LIMIT)) begin
      limit = CMP_W'(FIELD_LIMIT);
    end else begin
      limit = CMP_W'(max_fields);
    end
    at_limit = found_ext >= limit;
    ws       = byte_value == CH_SPACE || byte_value == CH_TAB;
    data_c   = is_data(byte_value);
  end

  always_comb begin
    result      = '0;
    mode_next   = mode;
    resume_next = resume;
    found_next  = found;
    if (byte_value == CH_NUL) begin
      result.line_done   = 1'b1;
      result.field_count = found_ext[cfs_pkg::COUNT_W-1:0];
      result.parse_error = mode == MODE_ERROR || mode == MODE_SLASH ||
                           mode == MODE_REMARK || mode == MODE_RSTAR;
      mode_next   = MODE_START;
      resume_next = 1'b0;
      found_next  = '0;
    end else begin
      case (mode)
        MODE_START: begin
          if (at_limit) begin
            mode_next = MODE_IGNORE;
          end else if (ws) begin
            mode_next = MODE_START;
          end else if (byte_value == CH_SLASH) begin
            resume_next = 1'b0;
            mode_next   = MODE_SLASH;
          end else if (data_c) begin
            result.field_start = 1'b1;
            result.field_byte  = 1'b1;
            result.field_index = found_ext[cfs_pkg::INDEX_W-1:0];
            found_next         = found_plus[CNT_W-1:0];
            mode_next          = MODE_DATA;
          end else if (byte_value == CH_COLON) begin
            // A colon where a field may start is an empty field of its own.
            result.field_start = 1'b1;
            result.field_index = found_ext[cfs_pkg::INDEX_W-1:0];
            found_next         = found_plus[CNT_W-1:0];
            mode_next          = (found_plus >= limit) ? MODE_IGNORE : MODE_START;
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        MODE_DATA, MODE_AFTER: begin
          if (mode == MODE_DATA && data_c) begin
            result.field_byte  = 1'b1;
            result.field_index = found_minus[cfs_pkg::INDEX_W-1:0];
          end else if (ws) begin
            mode_next = MODE_AFTER;
          end else if (byte_value == CH_SLASH) begin
            resume_next = 1'b1;
            mode_next   = MODE_SLASH;
          end else if (byte_value == CH_COLON) begin
            // This colon closes the open field and opens nothing.
            mode_next = at_limit ? MODE_IGNORE : MODE_START;
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        MODE_SLASH: begin
          mode_next = (byte_value == CH_STAR) ? MODE_REMARK : MODE_ERROR;
        end
        MODE_REMARK: begin
          if (byte_value == CH_STAR) begin
            mode_next = MODE_RSTAR;
          end
        end
        MODE_RSTAR: begin
          if (byte_value == CH_SLASH) begin
            mode_next = resume ? MODE_AFTER : MODE_START;
          end else if (byte_value != CH_STAR) begin
            mode_next = MODE_REMARK;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_START;
      resume <= 1'b0;
      found  <= '0;
    end else if (step) begin
      mode   <= mode_next;
      resume <= resume_next;
      found  <= found_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cfs_out_stage.sv @@
// Result register of the colon field splitter, driving the result channel.
// Depends on cfs_pkg and the cfs_result_if interface.
`default_nettype none

module cfs_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  cfs_result_if.source           result,
  input  wire logic              load,
  input  cfs_pkg::result_t       data,
  output logic                   space
);

  cfs_pkg::result_t held;

  // The register can take a new result when empty or when its request is taken now.
  assign space = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (space) begin
      result.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign result.field_start = held.field_start;
  assign result.field_byte  = held.field_byte;
  assign result.field_index = held.field_index;
  assign result.line_done   = held.line_done;
  assign result.field_count = held.field_count;
  assign result.parse_error = held.parse_error;

endmodule

`default_nettype wire

@@ rtl/core/colon_field_splitter_unit.sv @@
// Colon field splitter: a byte is taken every cycle while the result side takes its
// requests. An accepted byte is held in the input register, and its result is loaded into
// the result register when that register has space; it waits there until it is taken.
// The character decode and mode update stand between the two registers and keep the
// rate at one byte per cycle for as long as the result side takes its requests. A zero byte
// ends the line and carries the field count and error flag. max_fields is to be written
// by the user via cfg_we/cfg_wdata only while the block is idle, which it does not enforce.
// Values above FIELD_LIMIT act as FIELD_LIMIT. There is no clearing pass after reset.
// Depends on cfs_pkg, cfs_if, cfs_in_stage, cfs_parser and cfs_out_stage.
`default_nettype none

module colon_field_splitter_unit #(
  parameter int FIELD_LIMIT = cfs_pkg::FIELD_LIMIT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  cfs_line_if.sink                              line,
  cfs_result_if.source                          result,
  input  wire logic                             cfg_we,
  input  wire logic [cfs_pkg::MAX_FIELDS_W-1:0] cfg_wdata
);

  logic [cfs_pkg::MAX_FIELDS_W-1:0] max_fields;
  logic                             held_valid;
  logic [cfs_pkg::BYTE_W-1:0]       held_byte;
  logic                             space;
  logic                             advance;
  cfs_pkg::result_t                 step_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields <= cfs_pkg::MAX_FIELDS_RESET;
    end else if (cfg_we) begin
      max_fields <= cfg_wdata;
    end
  end

  assign advance = held_valid && space;

  cfs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .line       (line),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  cfs_parser #(
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .byte_value (held_byte),
    .max_fields (max_fields),
    .result     (step_result)
  );

  cfs_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .result (result),
    .load   (advance),
    .data   (step_result),
    .space  (space)
  );

`ifndef SYNTHESIS
  a_done_not_field: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.line_done |-> !result.field_start && !result.field_byte)
    else $error("line end result marks a field byte");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.line_done |->
      result.field_count <= max_fields && 32'(result.field_count) <= FIELD_LIMIT)
    else $error("field count beyond the field limit");

  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("parsed byte did not reach the result register");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.field_start && !result.field_byte |-> result.field_index == '0)
    else $error("field index set on a byte outside any field");
`endif

endmodule

`default_nettype wire

@@ sim/tb_colon_field_splitter_unit.sv @@
`timescale 1ns / 100ps
// Testbench for colon_field_splitter_unit: byte stream in, one result per byte out.
// Depends on cfs_pkg and the cfs_line_if / cfs_result_if channel interfaces.

module tb_colon_field_splitter_unit;
  import cfs_pkg::*;

  localparam int FIELD_LIMIT  = FIELD_LIMIT_DEFAULT;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [2:0] {
    MODE_START, MODE_DATA, MODE_AFTER, MODE_SLASH,
    MODE_REMARK, MODE_RSTAR, MODE_ERROR, MODE_IGNORE
  } line_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [MAX_FIELDS_W-1:0] cfg_wdata;

  cfs_line_if   line_ch();
  cfs_result_if result_ch();

  colon_field_splitter_unit dut (
    .clk(clk),
    .rst(rst),
    .line(line_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Model of the parser.
  line_mode_t              line_mode;
  bit                      remark_resumes_data;
  logic [COUNT_W-1:0]      fields_seen;
  logic [MAX_FIELDS_W-1:0] field_cap_reg;

  result_t    pending_results[$];
  logic [7:0] line_bytes[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_request;
  int  hold_left;
  int  cycle_count;
  int  fail_count;
  int  parsed_bytes;
  int  lines_checked;
  int  error_lines;
  int  results_checked;
  result_t want_res;
  result_t got_res;

  function automatic bit is_field_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic [COUNT_W-1:0] field_cap();
    return (field_cap_reg > FIELD_LIMIT) ? COUNT_W'(FIELD_LIMIT) : field_cap_reg;
  endfunction

  // Advances the parser by one byte and returns the result it produces.
  function automatic result_t parse_byte(input logic [7:0] c);
    result_t r;
    bit blank;
    r = '0;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    if (c == CH_NUL || !(line_mode inside {MODE_ERROR, MODE_IGNORE})) parsed_bytes++;
    if (c == CH_NUL) begin
      r.line_done   = 1'b1;
      r.field_count = fields_seen;
      r.parse_error = line_mode inside {MODE_ERROR, MODE_SLASH, MODE_REMARK, MODE_RSTAR};
      line_mode = MODE_START;
      remark_resumes_data = 1'b0;
      fields_seen = '0;
    end else begin
      case (line_mode)
        MODE_START: begin
          if (fields_seen >= field_cap()) begin
            line_mode = MODE_IGNORE;
          end else if (blank) begin
          end else if (c == CH_SLASH) begin
            remark_resumes_data = 1'b0;
            line_mode = MODE_SLASH;
          end else if (is_field_char(c) || c == CH_COLON) begin
            r.field_start = 1'b1;
            r.field_byte  = (c != CH_COLON);
            r.field_index = INDEX_W'(fields_seen);
            fields_seen++;
            if (c != CH_COLON) line_mode = MODE_DATA;
            else line_mode = (fields_seen >= field_cap()) ? MODE_IGNORE : MODE_START;
          end else begin
            line_mode = MODE_ERROR;
          end
        end
        MODE_DATA, MODE_AFTER: begin
          if (line_mode == MODE_DATA && is_field_char(c)) begin
            r.field_byte  = 1'b1;
            r.field_index = INDEX_W'(fields_seen - 7'd1);
          end else if (blank) begin
            line_mode = MODE_AFTER;
          end else if (c == CH_SLASH) begin
            remark_resumes_data = 1'b1;
            line_mode = MODE_SLASH;
          end else if (c == CH_COLON) begin
            line_mode = (fields_seen >= field_cap()) ? MODE_IGNORE : MODE_START;
          end else begin
            line_mode = MODE_ERROR;
          end
        end
        MODE_SLASH: line_mode = (c == CH_STAR) ? MODE_REMARK : MODE_ERROR;
        MODE_REMARK: if (c == CH_STAR) line_mode = MODE_RSTAR;
        MODE_RSTAR: begin
          if (c == CH_SLASH) line_mode = remark_resumes_data ? MODE_AFTER : MODE_START;
          else if (c != CH_STAR) line_mode = MODE_REMARK;
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // Clock, watchdog and receiver.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker.
  task automatic compare_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_res.field_start = result_ch.field_start;
      got_res.field_byte  = result_ch.field_byte;
      got_res.field_index = result_ch.field_index;
      got_res.line_done   = result_ch.line_done;
      got_res.field_count = result_ch.field_count;
      got_res.parse_error = result_ch.parse_error;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, got_res);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        compare_field("field_start", want_res.field_start, got_res.field_start);
        compare_field("field_byte", want_res.field_byte, got_res.field_byte);
        compare_field("field_index", want_res.field_index, got_res.field_index);
        compare_field("line_done", want_res.line_done, got_res.line_done);
        compare_field("field_count", want_res.field_count, got_res.field_count);
        compare_field("parse_error", want_res.parse_error, got_res.parse_error);
        results_checked++;
        if (want_res.line_done) begin
          lines_checked++;
          if (want_res.parse_error) error_lines++;
        end
      end
    end
  end

  // Sender side. Tasks are entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      line_ch.valid = 1'b0;
      @(negedge clk);
    end
    line_ch.valid = 1'b1;
    line_ch.byte_value = b;
    do @(posedge clk); while (!line_ch.ready);
    pending_results.push_back(parse_byte(b));
    @(negedge clk);
    line_ch.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  task automatic send_line_bytes();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    send_byte(CH_NUL);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_max_fields(input logic [MAX_FIELDS_W-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    field_cap_reg = value;
  endtask

  // Random line construction.
  function automatic logic [7:0] random_field_char();
    case ($urandom_range(0, 4))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      3: return CH_DASH;
      default: return CH_UNDER;
    endcase
  endfunction

  task automatic push_remark();
    int n;
    n = $urandom_range(0, 4);
    line_bytes.push_back(CH_SLASH);
    line_bytes.push_back(CH_STAR);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) line_bytes.push_back(8'($urandom_range(1, 255)));
      else if ($urandom_range(0, 5) == 0) line_bytes.push_back(CH_STAR);
      else line_bytes.push_back(random_field_char());
    end
    line_bytes.push_back(CH_STAR);
    line_bytes.push_back(CH_SLASH);
  endtask

  task automatic push_filler();
    case ($urandom_range(0, 5))
      0: line_bytes.push_back(CH_SPACE);
      1: begin
        line_bytes.push_back(CH_TAB);
        line_bytes.push_back(CH_SPACE);
      end
      2: push_remark();
      default: begin
      end
    endcase
  endtask

  // Mostly well-formed lines; a minority are broken in one of several ways.
  task automatic compose_line();
    int nf;
    int run_len;
    int kind;
    bit wide;
    line_bytes.delete();
    wide = ($urandom_range(0, 24) == 0);
    nf = wide ? $urandom_range(60, 68) : $urandom_range(1, 5);
    for (int i = 0; i < nf; i++) begin
      if (!wide) push_filler();
      if ($urandom_range(0, 3) == 0 || (wide && $urandom_range(0, 2) != 0)) begin
        line_bytes.push_back(CH_COLON);
      end else begin
        run_len = wide ? 1 : $urandom_range(1, 6);
        repeat (run_len) line_bytes.push_back(random_field_char());
        if (!wide) push_filler();
        if (i < nf - 1 || $urandom_range(0, 1)) line_bytes.push_back(CH_COLON);
      end
    end
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(1, 255));
    end else if (kind < 15) begin
      line_bytes.push_back(CH_SLASH);
      line_bytes.push_back(CH_STAR);
    end else if (kind < 20) begin
      line_bytes.insert($urandom_range(0, line_bytes.size()), CH_SPACE);
      line_bytes.push_back(random_field_char());
    end else if (kind < 23) begin
      line_bytes.push_back(CH_SLASH);
      line_bytes.push_back(random_field_char());
    end
  endtask

  // Tests.
  task automatic test_directed_lines();
    send_text("/**/a:b");
    send_text("a b");
    send_text("/x");
    send_text("/*/");
    send_text(" \t:");
    send_byte(8'hFF);
    send_byte(CH_NUL);
  endtask

  task automatic test_field_limit();
    write_max_fields(7'd1);
    send_text("a:b");
    send_text("ab c");
    write_max_fields(7'd0);
    send_text("a");
    write_max_fields(7'd127);
    send_text("x:");
    write_max_fields(MAX_FIELDS_RESET);
    repeat (66) send_byte(CH_COLON);
    send_byte(CH_NUL);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    logic [MAX_FIELDS_W-1:0] limit_list[3];
    int goal;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    limit_list[0] = MAX_FIELDS_RESET;
    limit_list[1] = MAX_FIELDS_W'($urandom_range(1, 6));
    limit_list[2] = ($urandom_range(0, 1) != 0) ? 7'd127 : MAX_FIELDS_W'($urandom_range(7, 126));
    foreach (limit_list[k]) begin
      write_max_fields(limit_list[k]);
      goal = parsed_bytes + 25;
      while (parsed_bytes < goal) begin
        compose_line();
        send_line_bytes();
      end
    end
  endtask

  // The receiver stops for a long stretch while bytes keep coming, then the
  // sender pauses until everything has drained.
  task automatic test_backpressure();
    int goal;
    send_idle_pct = 0;
    recv_idle_pct = 20;
    write_max_fields(MAX_FIELDS_RESET);
    hold_request = 1'b1;
    goal = parsed_bytes + 40;
    while (parsed_bytes < goal) begin
      compose_line();
      send_line_bytes();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    line_ch.valid = 1'b0;
    line_ch.byte_value = '0;
    line_mode = MODE_START;
    remark_resumes_data = 1'b0;
    fields_seen = '0;
    field_cap_reg = MAX_FIELDS_RESET;
    send_idle_pct = 14;
    recv_idle_pct = 49;
    hold_request = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    fail_count = 0;
    parsed_bytes = 0;
    lines_checked = 0;
    error_lines = 0;
    results_checked = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_directed_lines();
    test_field_limit();
    test_random_traffic(14, 49);
    test_random_traffic(49, 14);
    test_random_traffic(0, 0);
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    $display("Checked %0d byte results over %0d lines, %0d of them malformed.",
             results_checked, lines_checked, error_lines);
    $display("Field limits from 0 to 127 were used, with idle, stall and hold-off phases.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
